### hw/rtl/rvt_pkg.sv
// Shared types, widths and codes of the ray voxel traversal step core.
package rvt_pkg;

  localparam int MAX_CELLS = 256;
  localparam int COORD_W   = 32;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = $clog2(MAX_CELLS + 1);
  localparam int IDX_W     = $clog2(MAX_CELLS);
  localparam int ADDR_W    = $clog2(MAX_CELLS + 1);

  localparam int ZONE_W = 24;
  localparam int DIR_W  = 32;
  localparam int DIST_W = 32;
  localparam int SLOT_W = 9;
  localparam int AXIS_W = 2;

  localparam int MAG_W  = COORD_W + 1;
  localparam int QUOT_W = DIST_W - 1;
  localparam int DIV_LAT = QUOT_W + 1;

  localparam int SPLIT_BITS   = 4;
  localparam int SPLIT_STAGES = ZONE_W / SPLIT_BITS;
  localparam int SPLIT_LAT    = 2 * SPLIT_STAGES;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z = 2'd2;

  typedef struct packed {
    logic                     action;
    logic [AXIS_W-1:0]        edge_axis;
    logic [SLOT_W-1:0]        edge_slot;
    logic signed [31:0]       edge_value;
    logic [ZONE_W-1:0]        zone_index;
    logic signed [31:0]       pos_x;
    logic signed [31:0]       pos_y;
    logic signed [31:0]       pos_z;
    logic signed [DIR_W-1:0]  dir_x;
    logic signed [DIR_W-1:0]  dir_y;
    logic signed [DIR_W-1:0]  dir_z;
  } cmd_t;

  typedef struct packed {
    logic                     off_grid;
    logic [ZONE_W-1:0]        next_zone;
    logic signed [DIST_W-1:0] path_length;
  } res_t;

  // Per-item control carried alongside the face divisions.
  typedef struct packed {
    logic [2:0][IDX_W-1:0] cidx;
    logic                  off;
    logic [2:0]            neg;
    logic [2:0]            dir_zero;
    logic [2:0]            diff_zero;
    logic [2:0]            dir_neg;
  } trav_t;

endpackage

### hw/rtl/rvt_ram.sv
// Generic single-port-write RAM with registered read.
module rvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/rvt_zone_split.sv
// Pipelined split of a flat zone index into x, y and z cell numbers.
module rvt_zone_split (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rvt_pkg::ZONE_W-1:0] zone,
  input  logic [rvt_pkg::CNT_W-1:0]  cz,
  input  logic [rvt_pkg::CNT_W-1:0]  cy,
  output logic [rvt_pkg::ZONE_W-1:0] ix,
  output logic [rvt_pkg::CNT_W-1:0]  iy,
  output logic [rvt_pkg::CNT_W-1:0]  iz
);
  import rvt_pkg::*;

  // Restoring division, SPLIT_BITS quotient bits per stage.
  function automatic logic [ZONE_W+CNT_W-1:0] div_steps(
    input logic [ZONE_W-1:0] n_in,
    input logic [CNT_W-1:0]  r_in,
    input logic [CNT_W-1:0]  d
  );
    logic [ZONE_W-1:0] n;
    logic [CNT_W:0]    t;
    logic [CNT_W-1:0]  r;
    n = n_in;
    r = r_in;
    for (int i = 0; i < SPLIT_BITS; i++) begin
      t = {r, n[ZONE_W-1]};
      n = {n[ZONE_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t    = t - {1'b0, d};
        n[0] = 1'b1;
      end
      r = t[CNT_W-1:0];
    end
    return {n, r};
  endfunction

  logic [ZONE_W-1:0] num [SPLIT_LAT];
  logic [CNT_W-1:0]  rem [SPLIT_LAT];
  logic [CNT_W-1:0]  zr  [SPLIT_LAT];

  // First half divides by cz, second half divides the quotient by cy.
  for (genvar k = 0; k < SPLIT_LAT; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          {num[k], rem[k]} <= div_steps(zone, '0, cz);
          zr[k]            <= '0;
        end
      end
    end else if (k == SPLIT_STAGES) begin : g_mid
      always_ff @(posedge clk) begin
        if (en) begin
          {num[k], rem[k]} <= div_steps(num[k-1], '0, cy);
          zr[k]            <= rem[k-1];
        end
      end
    end else if (k < SPLIT_STAGES) begin : g_lo
      always_ff @(posedge clk) begin
        if (en) begin
          {num[k], rem[k]} <= div_steps(num[k-1], rem[k-1], cz);
          zr[k]            <= '0;
        end
      end
    end else begin : g_hi
      always_ff @(posedge clk) begin
        if (en) begin
          {num[k], rem[k]} <= div_steps(num[k-1], rem[k-1], cy);
          zr[k]            <= zr[k-1];
        end
      end
    end
  end

  assign ix = num[SPLIT_LAT-1];
  assign iy = rem[SPLIT_LAT-1];
  assign iz = zr[SPLIT_LAT-1];

endmodule

### hw/rtl/rvt_dist_div.sv
// Pipelined magnitude divider for one axis: min(mag * 2^30 / d, 2^31).
module rvt_dist_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rvt_pkg::MAG_W-1:0]  mag,
  input  logic [rvt_pkg::DIR_W-1:0]  dvs,
  output logic [rvt_pkg::QUOT_W-1:0] quot,
  output logic                       sat
);
  import rvt_pkg::*;

  localparam int CMP_W = (MAG_W > DIR_W + 1) ? MAG_W : DIR_W + 1;

  logic [DIR_W-1:0]  rem   [DIV_LAT];
  logic [DIR_W-1:0]  dd    [DIV_LAT];
  logic [QUOT_W-1:0] qq    [DIV_LAT];
  logic              satq  [DIV_LAT];
  logic              lsb;

  // Setup: quotient reaches 2^31 exactly when mag >= 2d; otherwise the
  // partial remainder starts at mag/2 and mag[0] is the first bit in.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= DIR_W'(mag >> 1);
      dd[0]   <= dvs;
      qq[0]   <= '0;
      satq[0] <= CMP_W'(mag) >= (CMP_W'(dvs) << 1);
      lsb     <= mag[0];
    end
  end

  for (genvar j = 1; j < DIV_LAT; j++) begin : g_step
    logic [DIR_W:0] t;
    logic           ge;
    always_comb begin
      t  = {rem[j-1], (j == 1) ? lsb : 1'b0};
      ge = t >= {1'b0, dd[j-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j]  <= ge ? DIR_W'(t - {1'b0, dd[j-1]}) : t[DIR_W-1:0];
        qq[j]   <= {qq[j-1][QUOT_W-2:0], ge};
        dd[j]   <= dd[j-1];
        satq[j] <= satq[j-1];
      end
    end
  end

  assign quot = qq[DIV_LAT-1];
  assign sat  = satq[DIV_LAT-1];

endmodule

### hw/rtl/ray_voxel_traversal_step_core.sv
// Top level of the ray voxel traversal step core.
//
// One ray step through a non-uniform 3D grid: the flat zone index is split
// into cell numbers, the facing edge of each axis is read from the edge
// tables, the distance to each plane is divided out, the nearest face wins
// (ties go to z, then y) and the neighbor zone or an off-grid flag comes
// back with the path length. Load items (action 0) write one edge entry and
// give no result. The core takes one item per cycle unless res is stalled;
// its pipeline depth is set by the two zone-split divisions (12 stages,
// 4 quotient bits each) and the bit-per-stage face division (32 stages,
// three in parallel). When res is stalled the whole pipeline holds and
// cmd_stall rises. Edge tables are plain RAMs with no clearing; an entry
// must be loaded before a step reads it. Configure the cell counts only
// while the pipeline is empty.
module ray_voxel_traversal_step_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  rvt_pkg::cmd_t                 cmd,
  output logic                          res_valid,
  input  logic                          res_stall,
  output rvt_pkg::res_t                 res,
  input  logic                          cfg_we,
  input  logic [rvt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rvt_pkg::CFG_W-1:0]     cfg_data
);
  import rvt_pkg::*;

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};

  // Global advance: the pipeline moves unless a result is held.
  logic en;
  assign en        = !(res_valid && res_stall);
  assign cmd_stall = res_valid && res_stall;

  // ---------------------------------------------------------------- config
  logic [CNT_W-1:0]   cells_x, cells_y, cells_z;
  logic [2*CNT_W-1:0] cells_yz;
  logic [CNT_W-1:0]   cfg_clamped;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = CNT_W'(1);
    end else if (cfg_data > CFG_W'(MAX_CELLS)) begin
      cfg_clamped = CNT_W'(MAX_CELLS);
    end else begin
      cfg_clamped = CNT_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x  <= CNT_W'(1);
      cells_y  <= CNT_W'(1);
      cells_z  <= CNT_W'(1);
      cells_yz <= (2*CNT_W)'(1);
    end else begin
      cells_yz <= cells_y * cells_z;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CELLS_X: cells_x <= cfg_clamped;
          CFG_CELLS_Y: cells_y <= cfg_clamped;
          CFG_CELLS_Z: cells_z <= cfg_clamped;
          default: ;
        endcase
      end
    end
  end

  // ------------------------------------------------------- input register
  logic v0;
  cmd_t c0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0 <= cmd;
    end
  end

  // ------------------------------------------------------------ zone split
  logic [ZONE_W-1:0] sp_ix;
  logic [CNT_W-1:0]  sp_iy, sp_iz;

  rvt_zone_split u_split (
    .clk  (clk),
    .en   (en),
    .zone (c0.zone_index),
    .cz   (cells_z),
    .cy   (cells_y),
    .ix   (sp_ix),
    .iy   (sp_iy),
    .iz   (sp_iz)
  );

  logic dl_v   [SPLIT_LAT];
  cmd_t dl_cmd [SPLIT_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SPLIT_LAT; k++) dl_v[k] <= 1'b0;
    end else if (en) begin
      dl_v[0] <= v0;
      for (int k = 1; k < SPLIT_LAT; k++) dl_v[k] <= dl_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_cmd[0] <= c0;
      for (int k = 1; k < SPLIT_LAT; k++) dl_cmd[k] <= dl_cmd[k-1];
    end
  end

  // ------------------------------------------- cell clamp and table access
  cmd_t                     ca;
  logic                     a_valid, a_load, a_step, a_off;
  logic [IDX_W-1:0]         a_cell [3];
  logic signed [DIR_W-1:0]  a_dir  [3];
  logic signed [COORD_W-1:0] a_pos [3];
  logic [ADDR_W-1:0]        a_addr [3];
  logic                     a_wok;
  logic [2:0]               a_we;

  always_comb begin
    ca      = dl_cmd[SPLIT_LAT-1];
    a_valid = dl_v[SPLIT_LAT-1];
    a_load  = a_valid && (ca.action == ACT_LOAD);
    a_step  = a_valid && (ca.action == ACT_STEP);
    // Zone index past the grid: clamp x and flag off grid.
    a_off     = sp_ix >= ZONE_W'(cells_x);
    a_cell[0] = a_off ? IDX_W'(cells_x - CNT_W'(1)) : IDX_W'(sp_ix);
    a_cell[1] = IDX_W'(sp_iy);
    a_cell[2] = IDX_W'(sp_iz);
    a_dir[0]  = ca.dir_x;
    a_dir[1]  = ca.dir_y;
    a_dir[2]  = ca.dir_z;
    a_pos[0]  = ca.pos_x[COORD_W-1:0];
    a_pos[1]  = ca.pos_y[COORD_W-1:0];
    a_pos[2]  = ca.pos_z[COORD_W-1:0];
    for (int a = 0; a < 3; a++) begin
      // Right edge only for a strictly positive direction.
      a_addr[a] = ADDR_W'(a_cell[a]) +
                  ADDR_W'(!a_dir[a][DIR_W-1] && (a_dir[a] != '0));
    end
    a_wok   = a_load && (ca.edge_slot <= SLOT_W'(MAX_CELLS));
    a_we[0] = en && a_wok && (ca.edge_axis == AXIS_X);
    a_we[1] = en && a_wok && (ca.edge_axis == AXIS_Y);
    a_we[2] = en && a_wok && (ca.edge_axis == AXIS_Z);
  end

  logic [COORD_W-1:0] b_edge [3];

  for (genvar g = 0; g < 3; g++) begin : g_tab
    rvt_ram #(
      .WIDTH (COORD_W),
      .DEPTH (MAX_CELLS + 1)
    ) u_edges (
      .clk   (clk),
      .we    (a_we[g]),
      .waddr (ADDR_W'(ca.edge_slot)),
      .wdata (ca.edge_value[COORD_W-1:0]),
      .re    (en),
      .raddr (a_addr[g]),
      .rdata (b_edge[g])
    );
  end

  logic                      b_v, b_off;
  logic [IDX_W-1:0]          b_cell [3];
  logic signed [DIR_W-1:0]   b_dir  [3];
  logic signed [COORD_W-1:0] b_pos  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_step;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_off <= a_off;
      for (int a = 0; a < 3; a++) begin
        b_cell[a] <= a_cell[a];
        b_dir[a]  <= a_dir[a];
        b_pos[a]  <= a_pos[a];
      end
    end
  end

  // ------------------------------------------------------------ difference
  logic                    d_v, d_off;
  logic [IDX_W-1:0]        d_cell [3];
  logic signed [DIR_W-1:0] d_dir  [3];
  logic signed [MAG_W-1:0] d_diff [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_off <= b_off;
      for (int a = 0; a < 3; a++) begin
        d_cell[a] <= b_cell[a];
        d_dir[a]  <= b_dir[a];
        d_diff[a] <= $signed({b_edge[a][COORD_W-1], b_edge[a]}) -
                     $signed({b_pos[a][COORD_W-1], b_pos[a]});
      end
    end
  end

  // ----------------------------------------------- magnitudes and signs
  logic             m_v;
  trav_t            m_trav;
  logic [MAG_W-1:0] m_mag [3];
  logic [DIR_W-1:0] m_dvs [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (en) begin
      m_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_trav.off <= d_off;
      for (int a = 0; a < 3; a++) begin
        m_trav.cidx[a]      <= d_cell[a];
        m_trav.neg[a]       <= d_diff[a][MAG_W-1] != d_dir[a][DIR_W-1];
        m_trav.dir_zero[a]  <= d_dir[a] == '0;
        m_trav.diff_zero[a] <= d_diff[a] == '0;
        m_trav.dir_neg[a]   <= d_dir[a][DIR_W-1];
        m_mag[a] <= d_diff[a][MAG_W-1] ? MAG_W'(-d_diff[a]) : MAG_W'(d_diff[a]);
        m_dvs[a] <= d_dir[a][DIR_W-1] ? DIR_W'(-d_dir[a]) : DIR_W'(d_dir[a]);
      end
    end
  end

  // ---------------------------------------------------------- face divide
  logic [QUOT_W-1:0] q_quot [3];
  logic              q_sat  [3];

  for (genvar g = 0; g < 3; g++) begin : g_div
    rvt_dist_div u_div (
      .clk  (clk),
      .en   (en),
      .mag  (m_mag[g]),
      .dvs  (m_dvs[g]),
      .quot (q_quot[g]),
      .sat  (q_sat[g])
    );
  end

  logic  dq_v    [DIV_LAT];
  trav_t dq_trav [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) dq_v[k] <= 1'b0;
    end else if (en) begin
      dq_v[0] <= m_v;
      for (int k = 1; k < DIV_LAT; k++) dq_v[k] <= dq_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq_trav[0] <= m_trav;
      for (int k = 1; k < DIV_LAT; k++) dq_trav[k] <= dq_trav[k-1];
    end
  end

  // ------------------------------------------------ signed saturated length
  trav_t                    qt;
  logic [DIST_W-1:0]        q_mag [3];
  logic signed [DIST_W-1:0] q_len [3];

  always_comb begin
    qt = dq_trav[DIV_LAT-1];
    for (int a = 0; a < 3; a++) begin
      q_mag[a] = q_sat[a] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, q_quot[a]};
      if (qt.dir_zero[a]) begin
        q_len[a] = DIST_MAX;
      end else if (qt.diff_zero[a]) begin
        q_len[a] = '0;
      end else if (qt.neg[a]) begin
        q_len[a] = -$signed(q_mag[a]);
      end else begin
        q_len[a] = q_mag[a][DIST_W-1] ? DIST_MAX : $signed(q_mag[a]);
      end
    end
  end

  logic                     l_v;
  trav_t                    l_trav;
  logic signed [DIST_W-1:0] l_len [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      l_v <= 1'b0;
    end else if (en) begin
      l_v <= dq_v[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_trav <= qt;
      for (int a = 0; a < 3; a++) l_len[a] <= q_len[a];
    end
  end

  // -------------------------------------------------------- face choice
  logic [AXIS_W-1:0] f_axis;

  always_comb begin
    priority if (l_len[0] < l_len[1] && l_len[0] < l_len[2]) begin
      f_axis = AXIS_X;
    end else if (l_len[1] < l_len[2]) begin
      f_axis = AXIS_Y;
    end else begin
      f_axis = AXIS_Z;
    end
  end

  logic                     c_v, c_off, c_dneg;
  logic [AXIS_W-1:0]        c_axis;
  logic [2:0][IDX_W-1:0]    c_cell;
  logic signed [DIST_W-1:0] c_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= l_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_axis <= f_axis;
      c_off  <= l_trav.off;
      c_cell <= l_trav.cidx;
      c_len  <= l_len[f_axis];
      c_dneg <= l_trav.dir_neg[f_axis];
    end
  end

  // ------------------------------------------------------------ step cell
  logic [2:0][IDX_W-1:0] s_cell_next;
  logic                  s_off_next;
  logic [CNT_W-1:0]      s_cnt;

  always_comb begin
    s_cell_next = c_cell;
    s_off_next  = c_off;
    unique case (c_axis)
      AXIS_X:  s_cnt = cells_x;
      AXIS_Y:  s_cnt = cells_y;
      default: s_cnt = cells_z;
    endcase
    if (c_dneg) begin
      if (c_cell[c_axis] == '0) begin
        s_off_next = 1'b1;
      end else begin
        s_cell_next[c_axis] = c_cell[c_axis] - IDX_W'(1);
      end
    end else begin
      if (CNT_W'(c_cell[c_axis]) + CNT_W'(1) >= s_cnt) begin
        s_off_next = 1'b1;
      end else begin
        s_cell_next[c_axis] = c_cell[c_axis] + IDX_W'(1);
      end
    end
  end

  logic                     s_v, s_off;
  logic [2:0][IDX_W-1:0]    s_cell;
  logic signed [DIST_W-1:0] s_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= 1'b0;
    end else if (en) begin
      s_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_off  <= s_off_next;
      s_cell <= s_cell_next;
      s_len  <= c_len;
    end
  end

  // ------------------------------------------------------- flat index
  logic                       p_v, p_off;
  logic [IDX_W+2*CNT_W-1:0]   p_x;
  logic [IDX_W+CNT_W-1:0]     p_y;
  logic [IDX_W-1:0]           p_z;
  logic signed [DIST_W-1:0]   p_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_off <= s_off;
      p_x   <= s_cell[0] * cells_yz;
      p_y   <= s_cell[1] * cells_z;
      p_z   <= s_cell[2];
      p_len <= s_len;
    end
  end

  logic [IDX_W+2*CNT_W:0] p_sum;
  assign p_sum = (IDX_W+2*CNT_W+1)'(p_x) + (IDX_W+2*CNT_W+1)'(p_y) +
                 (IDX_W+2*CNT_W+1)'(p_z);

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.off_grid    <= p_off;
      res.next_zone   <= p_off ? '0 : ZONE_W'(p_sum);
      res.path_length <= p_len;
    end
  end

endmodule

### hw/rtl/rvt_checker.sv
// Port-level checks for the ray voxel traversal step core, bound to the top.
module rvt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_stall,
  input rvt_pkg::cmd_t                 cmd,
  input logic                          res_valid,
  input logic                          res_stall,
  input rvt_pkg::res_t                 res,
  input logic                          cfg_we,
  input logic [rvt_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [rvt_pkg::CFG_W-1:0]     cfg_data
);
  import rvt_pkg::*;

  // Held result stays put.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // Input back-pressure comes only from a held result.
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    cmd_stall == (res_valid && res_stall))
    else $error("cmd_stall not tied to held result");

  // Off-grid results carry a zero neighbor index.
  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.off_grid |-> res.next_zone == '0)
    else $error("off-grid result with nonzero zone");

  // Pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid after reset");

endmodule

bind ray_voxel_traversal_step_core rvt_checker u_rvt_checker (.*);
